// ===== rtl/dht_pkg.sv =====
// Shared types, constants and register map of the DHT11 sensor reader.
`default_nettype none

package dht_pkg;

    localparam int NUM_PINS    = 32;
    localparam int FRAME_BYTES = 5;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int BIT_CNT_W   = 6;
    localparam int TICK_W      = 15;
    localparam int CFG_ADDR_W  = 5;

    localparam logic [31:0] PIN_RANGE = 32'hFFFF_FFFF >> (32 - NUM_PINS);

    localparam logic [2:0] REG_START_LOW  = 3'd0;
    localparam logic [2:0] REG_RELEASE    = 3'd1;
    localparam logic [2:0] REG_LOW_MIN    = 3'd2;
    localparam logic [2:0] REG_LOW_MAX    = 3'd3;
    localparam logic [2:0] REG_HIGH_MIN   = 3'd4;
    localparam logic [2:0] REG_HIGH_MAX   = 3'd5;
    localparam logic [2:0] REG_SAMPLE     = 3'd6;
    localparam logic [2:0] REG_TIMEOUT    = 3'd7;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_RESP  = 2'd1;
    localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [31:0] line_levels;
        logic [31:0] pin_mask;
    } t_in_req;

    typedef struct packed {
        logic [31:0] drive_mask;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [31:0] reading;
    } t_out_res;

    typedef struct packed {
        logic [14:0] start_low_us;
        logic [7:0]  release_wait_us;
        logic [7:0]  resp_low_min;
        logic [7:0]  resp_low_max;
        logic [7:0]  resp_high_min;
        logic [7:0]  resp_high_max;
        logic [7:0]  sample_delay_us;
        logic [7:0]  timeout_us;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/dht11_sensor_reader.sv =====
// Top level of the DHT11 sensor reader: request and result registers around the state machine.
// A request is held in the request register; its result is registered into the result register once that is free.
// Throughput: one request per cycle while results are taken; a stalled result holds while the request register fills.
// Each request's step is one pass of short logic between the request and result registers.
// Reset is synchronous and active low; it idles the transaction and restores register defaults.
`default_nettype none

module dht11_sensor_reader (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire dht_pkg::t_in_req               i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output dht_pkg::t_out_res                   o_out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [dht_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import dht_pkg::*;

    t_cfg     cfg;
    t_out_res res;
    t_in_req  r_in;
    logic     r_in_valid;
    t_out_res r_out;
    logic     r_out_valid;
    logic     adv;

    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    dht_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dht_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dht_cfg_regs.sv =====
// APB-style configuration register file of the DHT11 sensor reader.
`default_nettype none

module dht_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dht_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output dht_pkg::t_cfg                      o_cfg
);
    import dht_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_us    <= 15'd20000;
            r_cfg.release_wait_us <= 8'd25;
            r_cfg.resp_low_min    <= 8'd8;
            r_cfg.resp_low_max    <= 8'd58;
            r_cfg.resp_high_min   <= 8'd5;
            r_cfg.resp_high_max   <= 8'd42;
            r_cfg.sample_delay_us <= 8'd40;
            r_cfg.timeout_us      <= 8'd100;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_START_LOW: r_cfg.start_low_us    <= pwdata[14:0];
                REG_RELEASE:   r_cfg.release_wait_us <= pwdata[7:0];
                REG_LOW_MIN:   r_cfg.resp_low_min    <= pwdata[7:0];
                REG_LOW_MAX:   r_cfg.resp_low_max    <= pwdata[7:0];
                REG_HIGH_MIN:  r_cfg.resp_high_min   <= pwdata[7:0];
                REG_HIGH_MAX:  r_cfg.resp_high_max   <= pwdata[7:0];
                REG_SAMPLE:    r_cfg.sample_delay_us <= pwdata[7:0];
                REG_TIMEOUT:   r_cfg.timeout_us      <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_LOW: prdata = {17'd0, r_cfg.start_low_us};
            REG_RELEASE:   prdata = {24'd0, r_cfg.release_wait_us};
            REG_LOW_MIN:   prdata = {24'd0, r_cfg.resp_low_min};
            REG_LOW_MAX:   prdata = {24'd0, r_cfg.resp_low_max};
            REG_HIGH_MIN:  prdata = {24'd0, r_cfg.resp_high_min};
            REG_HIGH_MAX:  prdata = {24'd0, r_cfg.resp_high_max};
            REG_SAMPLE:    prdata = {24'd0, r_cfg.sample_delay_us};
            REG_TIMEOUT:   prdata = {24'd0, r_cfg.timeout_us};
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/dht_fsm.sv =====
// Transaction state machine: one tick or start request per step, result computed combinationally.
`default_nettype none

module dht_fsm (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire dht_pkg::t_in_req  i_req,
    input  wire dht_pkg::t_cfg     i_cfg,
    output dht_pkg::t_out_res      o_res
);
    import dht_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_RELEASE,
        PH_RESP_LOW,
        PH_RESP_HIGH,
        PH_WAIT_FALL,
        PH_WAIT_RISE,
        PH_DELAY
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [TICK_W-1:0]     r_tick, n_tick;
    logic [BIT_CNT_W-1:0]  r_bits, n_bits;
    logic [FRAME_BITS-1:0] r_shift, n_shift;
    logic [31:0]           r_watched, n_watched;

    logic          hi;
    logic [TICK_W:0] tick_inc;
    logic          do_low, do_high;
    logic [TICK_W-1:0] lc, hc;
    logic [TICK_W:0] lc_inc, hc_inc, lv, hv;
    logic          l_ev, l_carry, h_ev, h_carry;
    logic          take, take_hi;
    logic          fin;
    logic [1:0]    fin_status;
    logic [7:0]    sum8;

    assign tick_inc = {1'b0, r_tick} + {{TICK_W{1'b0}}, 1'b1};

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bits     = r_bits;
        n_shift    = r_shift;
        n_watched  = r_watched;
        do_low     = 1'b0;
        do_high    = 1'b0;
        lc         = '0;
        hc         = '0;
        lc_inc     = '0;
        hc_inc     = '0;
        lv         = '0;
        hv         = '0;
        l_ev       = 1'b0;
        l_carry    = 1'b0;
        h_ev       = 1'b0;
        h_carry    = 1'b0;
        take       = 1'b0;
        take_hi    = 1'b0;
        fin        = 1'b0;
        fin_status = STATUS_OK;
        sum8       = '0;
        hi         = |(i_req.line_levels & r_watched);

        if (i_req.req_type) begin
            n_watched = i_req.pin_mask & PIN_RANGE;
            n_phase   = PH_START;
            n_tick    = '0;
            n_bits    = '0;
            n_shift   = '0;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_START: begin
                    if (tick_inc >= {1'b0, i_cfg.start_low_us}) begin
                        n_phase = PH_RELEASE;
                        n_tick  = '0;
                    end else begin
                        n_tick = tick_inc[TICK_W-1:0];
                    end
                end
                PH_RELEASE: begin
                    if (tick_inc >= {8'd0, i_cfg.release_wait_us}) begin
                        do_low = 1'b1;
                        lc     = '0;
                    end else begin
                        n_tick = tick_inc[TICK_W-1:0];
                    end
                end
                PH_RESP_LOW: begin
                    do_low = 1'b1;
                    lc     = r_tick;
                end
                PH_RESP_HIGH: begin
                    do_high = 1'b1;
                    hc      = r_tick;
                end
                PH_WAIT_FALL: begin
                    if (!hi) begin
                        n_phase = PH_WAIT_RISE;
                    end
                end
                PH_WAIT_RISE: begin
                    if (hi) begin
                        n_tick = '0;
                        if (i_cfg.sample_delay_us == 8'd0) begin
                            take    = 1'b1;
                            take_hi = 1'b1;
                        end else begin
                            n_phase = PH_DELAY;
                        end
                    end
                end
                PH_DELAY: begin
                    if (tick_inc >= {8'd0, i_cfg.sample_delay_us}) begin
                        n_tick  = '0;
                        take    = 1'b1;
                        take_hi = hi;
                    end else begin
                        n_tick = tick_inc[TICK_W-1:0];
                    end
                end
            endcase

            if (do_low) begin
                lc_inc = {1'b0, lc} + {{TICK_W{1'b0}}, 1'b1};
                if (!hi) begin
                    if (lc_inc > {8'd0, i_cfg.timeout_us}) begin
                        l_ev = 1'b1;
                        lv   = lc_inc;
                    end else begin
                        n_phase = PH_RESP_LOW;
                        n_tick  = lc_inc[TICK_W-1:0];
                    end
                end else begin
                    l_ev    = 1'b1;
                    l_carry = 1'b1;
                    lv      = {1'b0, lc};
                end
                if (l_ev) begin
                    if (lv > {8'd0, i_cfg.resp_low_max} || lv < {8'd0, i_cfg.resp_low_min}) begin
                        fin        = 1'b1;
                        fin_status = STATUS_NO_RESP;
                        n_phase    = PH_IDLE;
                        n_tick     = '0;
                    end else begin
                        n_phase = PH_RESP_HIGH;
                        n_tick  = '0;
                        if (l_carry) begin
                            do_high = 1'b1;
                            hc      = '0;
                        end
                    end
                end
            end

            if (do_high) begin
                hc_inc = {1'b0, hc} + {{TICK_W{1'b0}}, 1'b1};
                if (hi) begin
                    if (hc_inc > {8'd0, i_cfg.timeout_us}) begin
                        h_ev = 1'b1;
                        hv   = hc_inc;
                    end else begin
                        n_phase = PH_RESP_HIGH;
                        n_tick  = hc_inc[TICK_W-1:0];
                    end
                end else begin
                    h_ev    = 1'b1;
                    h_carry = 1'b1;
                    hv      = {1'b0, hc};
                end
                if (h_ev) begin
                    if (hv > {8'd0, i_cfg.resp_high_max} || hv < {8'd0, i_cfg.resp_high_min}) begin
                        fin        = 1'b1;
                        fin_status = STATUS_NO_RESP;
                        n_phase    = PH_IDLE;
                        n_tick     = '0;
                    end else begin
                        n_tick  = '0;
                        n_phase = h_carry ? PH_WAIT_RISE : PH_WAIT_FALL;
                    end
                end
            end

            if (take) begin
                n_shift = {r_shift[FRAME_BITS-2:0], take_hi};
                n_bits  = r_bits + {{(BIT_CNT_W-1){1'b0}}, 1'b1};
                if (n_bits >= BIT_CNT_W'(FRAME_BITS)) begin
                    sum8    = n_shift[39:32] + n_shift[31:24] + n_shift[23:16] + n_shift[15:8];
                    fin     = 1'b1;
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    fin_status = (sum8 == n_shift[7:0]) ? STATUS_OK : STATUS_CHECKSUM;
                end else begin
                    n_phase = PH_WAIT_FALL;
                end
            end
        end
    end

    always_comb begin
        o_res.drive_mask = (n_phase == PH_START) ? n_watched : 32'd0;
        o_res.busy_res   = (n_phase != PH_IDLE);
        o_res.done_res   = fin;
        o_res.status     = fin ? fin_status : STATUS_OK;
        o_res.reading    = (fin && fin_status == STATUS_OK) ? n_shift[39:8] : 32'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_bits    <= '0;
            r_shift   <= '0;
            r_watched <= '0;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bits    <= n_bits;
            r_shift   <= n_shift;
            r_watched <= n_watched;
        end
    end

    a_start_enters_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_req.req_type |=> r_phase == PH_START)
        else $error("start request did not enter the start phase");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= BIT_CNT_W'(FRAME_BITS))
        else $error("bit counter ran past the frame length");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done_res |-> !o_res.busy_res && o_res.drive_mask == 32'd0)
        else $error("finished transaction still reported busy or driving");

    a_reading_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.reading != 32'd0 |-> o_res.done_res && o_res.status == STATUS_OK)
        else $error("reading shown without a good finish");

    a_idle_holds_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_tick == '0)
        else $error("tick counter not cleared while idle");

endmodule

`default_nettype wire
